@@ rtl/cqre_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqre_pkg: shared types and codes of the cigar region extractor
// operation codes, result kinds, error codes, config indexes and the
// transaction types that move between the front, the queue and the back
// ----------------------------------------------------------------------------
package cqre_pkg;

    // cigar operation codes
    localparam logic [3:0] OP_M  = 4'd0;
    localparam logic [3:0] OP_I  = 4'd1;
    localparam logic [3:0] OP_D  = 4'd2;
    localparam logic [3:0] OP_N  = 4'd3;
    localparam logic [3:0] OP_S  = 4'd4;
    localparam logic [3:0] OP_H  = 4'd5;
    localparam logic [3:0] OP_P  = 4'd6;
    localparam logic [3:0] OP_EQ = 4'd7;
    localparam logic [3:0] OP_X  = 4'd8;

    // result kinds
    localparam logic [1:0] KIND_COPY    = 2'd0;
    localparam logic [1:0] KIND_FILL    = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NO_OVERLAP = 2'd0;
    localparam logic [1:0] ERR_ZERO_LEN   = 2'd1;
    localparam logic [1:0] ERR_QUERY_OOR  = 2'd2;

    // config register indexes
    localparam logic [1:0] CFG_REGION_START = 2'd0;
    localparam logic [1:0] CFG_REGION_END   = 2'd1;
    localparam logic [1:0] CFG_KEEP_SOFT    = 2'd2;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic        first_op;
        logic        last_op;
        logic [3:0]  op_code;
        logic [27:0] op_len;
        logic [30:0] align_pos;
        logic [30:0] align_end;
        logic [30:0] query_len;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [30:0]        query_offset;
        logic [27:0]        seg_len;
        logic [30:0]        span_start;
        logic signed [31:0] span_end;
        logic [1:0]         error_code;
        logic               last_out;
    } out_item_t;

    // everything one cigar operation produces
    typedef struct packed {
        logic        seg_valid;
        out_item_t   seg;
        logic        sum_valid;
        logic [30:0] sum_start;
        logic [31:0] sum_end;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } queue_wr_t;

endpackage

@@ rtl/cqre_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqre_front: cigar walk front end
// holds config and walk state, classifies each operation against the region
// and writes the segment and summary it causes into the queue
// ----------------------------------------------------------------------------
module cqre_front #(
    parameter int POS_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [30:0]         cfg_data,
    input  cqre_pkg::in_item_t  item,
    input  logic                accept,
    input  logic                full,
    output cqre_pkg::queue_wr_t wr
);

    localparam int CMP_BITS = ((POS_BITS > 31) ? POS_BITS : 31) + 1;

    logic [30:0]         region_start_reg;
    logic [30:0]         region_end_reg;
    logic                keep_soft_reg;
    logic [POS_BITS-1:0] ref_cursor_reg;
    logic [POS_BITS-1:0] query_cursor_reg;
    logic [30:0]         align_start_reg;
    logic                stopped_reg;
    logic                failed_reg;

    logic [POS_BITS-1:0] ref_cursor_next;
    logic [POS_BITS-1:0] query_cursor_next;
    logic                stopped_next;
    logic                failed_next;

    logic [POS_BITS-1:0] rc_cur;
    logic [POS_BITS-1:0] qc_cur;
    logic [30:0]         held_cur;
    logic                stopped_cur;
    logic                failed_cur;
    logic                no_overlap;

    logic                cref;
    logic                cqry;
    logic                is_ins;
    logic                is_skip;

    logic [CMP_BITS-1:0] r_w;
    logic [CMP_BITS-1:0] q_w;
    logic [CMP_BITS-1:0] olen_w;
    logic [CMP_BITS-1:0] rs_w;
    logic [CMP_BITS-1:0] re_w;
    logic [CMP_BITS-1:0] qlen_w;
    logic [CMP_BITS-1:0] clip_w;
    logic [CMP_BITS-1:0] rc_next_w;

    logic                active;
    logic                left_of_region;
    logic                over;
    logic                stop;
    logic                clip;
    logic                in_region;
    logic [27:0]         seg_len;
    logic                len_zero;
    logic                q_over;
    logic                seg_err;
    logic                advance;

    always_comb
    begin
        cref    = 1'b0;
        cqry    = 1'b0;
        is_ins  = 1'b0;
        is_skip = 1'b0;
        case (item.op_code)
            cqre_pkg::OP_M,
            cqre_pkg::OP_EQ,
            cqre_pkg::OP_X:
            begin
                cref = 1'b1;
                cqry = 1'b1;
            end
            cqre_pkg::OP_I:
            begin
                cqry   = 1'b1;
                is_ins = 1'b1;
            end
            cqre_pkg::OP_D:
            begin
                cref = 1'b1;
            end
            cqre_pkg::OP_N:
            begin
                cref    = 1'b1;
                is_skip = 1'b1;
            end
            cqre_pkg::OP_S:
            begin
                cqry = keep_soft_reg;
            end
            default:
            begin
                // hard clip, pad and unknown codes consume nothing
                cref = 1'b0;
            end
        endcase
    end

    // a first op restarts the walk
    assign rc_cur      = item.first_op ? POS_BITS'(item.align_pos) : ref_cursor_reg;
    assign qc_cur      = item.first_op ? '0 : query_cursor_reg;
    assign held_cur    = item.first_op ? item.align_pos : align_start_reg;
    assign stopped_cur = item.first_op ? 1'b0 : stopped_reg;
    assign failed_cur  = item.first_op ? 1'b0 : failed_reg;
    assign no_overlap  = item.first_op &&
                         ((region_start_reg > item.align_end) ||
                          (region_end_reg < item.align_pos));

    assign r_w    = CMP_BITS'(rc_cur);
    assign q_w    = CMP_BITS'(qc_cur);
    assign olen_w = CMP_BITS'(item.op_len);
    assign rs_w   = CMP_BITS'(region_start_reg);
    assign re_w   = CMP_BITS'(region_end_reg);
    assign qlen_w = CMP_BITS'(item.query_len);

    assign active         = !failed_cur && !no_overlap;
    assign left_of_region = r_w < rs_w;
    assign over           = (r_w + olen_w) > re_w;
    assign stop           = ((r_w > re_w) && !is_ins) || (is_skip && over);
    assign clip           = over && !is_ins;
    assign in_region      = active && !left_of_region && !stopped_cur && !stop;

    // clipped length, only used while the cursor is inside the region
    assign clip_w   = re_w - r_w + CMP_BITS'(1);
    assign seg_len  = clip ? clip_w[27:0] : item.op_len;
    assign len_zero = !clip && (item.op_len == '0);
    assign q_over   = clip ? ((q_w + clip_w) > qlen_w) : ((q_w + olen_w) > qlen_w);
    assign seg_err  = in_region && cqry && (len_zero || q_over);
    assign advance  = active && (left_of_region || (in_region && !seg_err));

    assign ref_cursor_next   = (advance && cref) ? rc_cur + POS_BITS'(item.op_len) : rc_cur;
    assign query_cursor_next = (advance && cqry) ? qc_cur + POS_BITS'(item.op_len) : qc_cur;
    assign stopped_next      = stopped_cur || (active && !left_of_region && !stopped_cur && stop);
    assign failed_next       = failed_cur || no_overlap || seg_err;

    assign rc_next_w = CMP_BITS'(ref_cursor_next);

    always_comb
    begin
        wr = '0;
        if (no_overlap)
        begin
            wr.entry.seg_valid      = 1'b1;
            wr.entry.seg.kind       = cqre_pkg::KIND_ERROR;
            wr.entry.seg.error_code = cqre_pkg::ERR_NO_OVERLAP;
            wr.entry.seg.last_out   = 1'b1;
        end
        else if (!failed_cur)
        begin
            if (seg_err)
            begin
                wr.entry.seg_valid      = 1'b1;
                wr.entry.seg.kind       = cqre_pkg::KIND_ERROR;
                wr.entry.seg.error_code = len_zero ? cqre_pkg::ERR_ZERO_LEN
                                                   : cqre_pkg::ERR_QUERY_OOR;
                wr.entry.seg.last_out   = 1'b1;
            end
            else if (in_region && cqry)
            begin
                wr.entry.seg_valid        = 1'b1;
                wr.entry.seg.kind         = cqre_pkg::KIND_COPY;
                wr.entry.seg.query_offset = 31'(qc_cur);
                wr.entry.seg.seg_len      = seg_len;
            end
            else if (in_region && cref)
            begin
                wr.entry.seg_valid    = 1'b1;
                wr.entry.seg.kind     = cqre_pkg::KIND_FILL;
                wr.entry.seg.seg_len  = seg_len;
            end
            wr.entry.sum_valid = item.last_op && !seg_err;
            wr.entry.sum_start = (held_cur > region_start_reg) ? held_cur : region_start_reg;
            wr.entry.sum_end   = (rc_next_w <= re_w) ? 32'(rc_next_w - CMP_BITS'(1))
                                                     : 32'(region_end_reg);
        end
        wr.valid = accept && (wr.entry.seg_valid || wr.entry.sum_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start_reg <= '0;
            region_end_reg   <= '0;
            keep_soft_reg    <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                cqre_pkg::CFG_REGION_START: region_start_reg <= cfg_data;
                cqre_pkg::CFG_REGION_END:   region_end_reg   <= cfg_data;
                cqre_pkg::CFG_KEEP_SOFT:    keep_soft_reg    <= cfg_data[0];
                default:                    keep_soft_reg    <= keep_soft_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_cursor_reg   <= '0;
            query_cursor_reg <= '0;
            align_start_reg  <= '0;
            stopped_reg      <= 1'b0;
            failed_reg       <= 1'b0;
        end
        else if (accept)
        begin
            ref_cursor_reg   <= ref_cursor_next;
            query_cursor_reg <= query_cursor_next;
            align_start_reg  <= held_cur;
            stopped_reg      <= stopped_next;
            failed_reg       <= failed_next;
        end
    end

    // an error ends the alignment: no summary with it, and the walk fails
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr.valid && wr.entry.seg.kind == cqre_pkg::KIND_ERROR) |-> !wr.entry.sum_valid)
        else $error("error transaction carries a summary");

    assert property (@(posedge clk) disable iff (!rst_n)
        (wr.valid && wr.entry.seg_valid && wr.entry.seg.kind == cqre_pkg::KIND_ERROR)
        |=> failed_reg)
        else $error("walk not failed after error");

    assert property (@(posedge clk) disable iff (!rst_n)
        wr.valid |-> !full)
        else $error("queue write while full");

endmodule

@@ rtl/cqre_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqre_queue: short queue between front and back
// register based fifo of per-operation entries
// ----------------------------------------------------------------------------
module cqre_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  cqre_pkg::queue_wr_t wr,
    input  logic                rd,
    output cqre_pkg::entry_t    head,
    output logic                head_valid,
    output logic                full
);

    localparam int PB = cqre_pkg::QUEUE_PTR_BITS;

    cqre_pkg::entry_t  mem_reg [cqre_pkg::QUEUE_DEPTH];
    logic [PB-1:0]     wr_ptr_reg;
    logic [PB-1:0]     rd_ptr_reg;
    logic [PB:0]       count_reg;
    logic [PB:0]       count_next;
    logic              do_rd;

    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = count_reg != '0;
    assign full       = count_reg == (PB+1)'(cqre_pkg::QUEUE_DEPTH);
    assign do_rd      = rd && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (wr.valid && !do_rd)
        begin
            count_next = count_reg + (PB+1)'(1);
        end
        else if (!wr.valid && do_rd)
        begin
            count_next = count_reg - (PB+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.valid)
        begin
            mem_reg[wr_ptr_reg] <= wr.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + PB'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + PB'(1);
            end
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PB+1)'(cqre_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");

endmodule

@@ rtl/cqre_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqre_back: result sequencer
// hands out the segment and then the summary of each queued entry
// ----------------------------------------------------------------------------
module cqre_back (
    input  logic                clk,
    input  logic                rst_n,
    input  cqre_pkg::entry_t    head,
    input  logic                head_valid,
    output logic                rd,
    output cqre_pkg::out_item_t result,
    output logic                empty,
    input  logic                pop
);

    logic phase_reg;
    logic phase_next;
    logic show_seg;
    logic taken;

    assign show_seg = head.seg_valid && !phase_reg;
    assign empty    = !head_valid;
    assign taken    = pop && head_valid;

    always_comb
    begin
        if (show_seg)
        begin
            result = head.seg;
        end
        else
        begin
            result            = '0;
            result.kind       = cqre_pkg::KIND_SUMMARY;
            result.span_start = head.sum_start;
            result.span_end   = head.sum_end;
            result.last_out   = 1'b1;
        end
    end

    always_comb
    begin
        rd         = 1'b0;
        phase_next = phase_reg;
        if (taken)
        begin
            if (show_seg && head.sum_valid)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                rd         = 1'b1;
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (head_valid && head.seg_valid && head.sum_valid))
        else $error("summary phase without a two-result entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        (taken && show_seg && head.sum_valid) |=> (phase_reg && !empty))
        else $error("summary lost after segment transaction");

endmodule

@@ rtl/cigar_query_region_extract.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cigar_query_region_extract: cigar walk against a reference region
// turns the cigar operations of an alignment into query-copy and gap-fill
// segment descriptors, a summary with the covered span, or an error
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload             transaction when
//  -------   ------------------   -----------------   ------------------------
//  input     push / full          item   (in_item_t)  push && !full
//  result    pop / empty          result (out_item_t) pop && !empty
//  config    cfg_wr_en            cfg_index, cfg_data cfg_wr_en
//
//  one cigar operation per cycle enters the front while full is low; its
//  cursor update and region checks finish in that cycle
//  an operation yields up to two results, handed out one per cycle by the
//  back while pop is high, so an operation with segment and summary holds
//  the result side for both; a four-entry queue lets the input keep running
//  meanwhile; full rises only when the queue holds four undelivered entries
//  reset clears the config, the walk state and the queue; no clearing pass
//
module cigar_query_region_extract #(
    parameter int POS_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration writes
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [30:0]         cfg_data,
    // cigar operations in
    input  logic                push,
    output logic                full,
    input  cqre_pkg::in_item_t  item,
    // results out
    output logic                empty,
    input  logic                pop,
    output cqre_pkg::out_item_t result
);

    cqre_pkg::queue_wr_t wr;
    cqre_pkg::entry_t    head;
    logic                head_valid;
    logic                rd;
    logic                accept;

    // input transaction
    assign accept = push && !full;

    // front: config, cursors and per-operation classification
    cqre_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .accept    (accept),
        .full      (full),
        .wr        (wr)
    );

    // queue decouples the walk from the result side
    cqre_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .rd         (rd),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    // back: one result transaction per cycle while pop is high, segment before summary
    cqre_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .rd         (rd),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule
